// ===== rtl/tsp_pkg.sv =====
// Shared types and constants for the transport stream section packetizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tsp_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'h47;
  localparam logic [7:0]  STUFF_BYTE     = 8'hFF;
  localparam logic [7:0]  POINTER_BYTE   = 8'h00;
  localparam logic [3:0]  PAYLOAD_FLAG   = 4'h1;
  localparam logic [7:0]  PACKET_PAYLOAD = 8'd184;
  localparam logic [12:0] LEN_BIAS       = 13'd3;
  localparam logic [7:0]  SINGLE_REPEAT  = 8'd1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_FIRST,
    HDR_NEXT
  } hdr_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [12:0] packet_id;
    logic [3:0]  start_count;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       section_done;
  } result_t;

  typedef struct packed {
    hdr_kind_t   hdr;
    logic [12:0] pid;
    logic [3:0]  cc;
    logic [7:0]  data;
    logic [7:0]  pad;
    logic        done;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/tsp_front.sv =====
// Front end: accepts section bytes, tracks framing state, and emits one
// descriptor per byte that produces output. Depends on tsp_pkg.
`default_nettype none
module tsp_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             item_valid,
  output logic            item_stall,
  input  tsp_pkg::item_t  item,
  input  wire             q_full,
  output logic            push,
  output tsp_pkg::desc_t  push_desc
);
  import tsp_pkg::*;

  logic [12:0] byte_position;
  logic [12:0] total_length;
  logic [7:0]  packet_fill;
  logic [3:0]  continuity;
  logic [12:0] held_id;
  logic        active;

  logic        accept;
  logic [12:0] base_pos;
  logic [12:0] base_len;
  logic [7:0]  base_fill;
  logic [12:0] pos_next;
  logic [12:0] len_next;
  logic [7:0]  fill_inc;
  logic        ends;
  logic        wraps;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    push_desc.data = item.data_byte;
    if (item.first_byte) begin
      push_desc.hdr = HDR_FIRST;
      push_desc.pid = item.packet_id;
      push_desc.cc  = item.start_count;
      base_pos      = '0;
      base_len      = '0;
      base_fill     = 8'd1;
    end else begin
      push_desc.hdr = (packet_fill == '0) ? HDR_NEXT : HDR_NONE;
      push_desc.pid = held_id;
      push_desc.cc  = continuity;
      base_pos      = byte_position;
      base_len      = total_length;
      base_fill     = packet_fill;
    end

    priority if (base_pos == 13'd1) begin
      len_next = {1'b0, item.data_byte[3:0], 8'h00};
    end else if (base_pos == 13'd2) begin
      len_next = (base_len | {5'b0, item.data_byte}) + LEN_BIAS;
    end else begin
      len_next = base_len;
    end

    pos_next = base_pos + 13'd1;
    fill_inc = base_fill + 8'd1;
    ends     = (pos_next >= LEN_BIAS) && (pos_next == len_next);
    wraps    = fill_inc >= PACKET_PAYLOAD;

    push_desc.done = ends;
    push_desc.pad  = (ends && !wraps) ? (PACKET_PAYLOAD - fill_inc) : '0;
    push           = accept && (item.first_byte || active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      total_length  <= '0;
      packet_fill   <= '0;
      continuity    <= '0;
      held_id       <= '0;
      active        <= 1'b0;
    end else if (push) begin
      byte_position <= pos_next;
      total_length  <= len_next;
      held_id       <= push_desc.pid;
      active        <= !ends;
      packet_fill   <= (ends || wraps) ? '0 : fill_inc;
      continuity    <= (!ends && wraps) ? push_desc.cc + 4'd1 : push_desc.cc;
    end
  end

  a_no_push_inactive: assert property (@(posedge clk) disable iff (rst)
    accept && !item.first_byte && !active |-> !push)
    else $error("word pushed while no section active");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    push && push_desc.hdr == HDR_FIRST |-> !push_desc.done)
    else $error("section ended on its first byte");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    packet_fill < PACKET_PAYLOAD)
    else $error("packet fill out of range");

endmodule
`default_nettype wire

// ===== rtl/tsp_queue.sv =====
// Descriptor queue between front and back end.
// Depends on tsp_pkg for the descriptor type and depth.
`default_nettype none
module tsp_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  tsp_pkg::desc_t  push_desc,
  output logic            full,
  input  wire             pop,
  output logic            head_valid,
  output tsp_pkg::desc_t  head
);
  import tsp_pkg::*;

  desc_t            entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign full       = count == QCW'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/tsp_back.sv =====
// Back end: expands each descriptor into header, data and padding words,
// one per cycle while the output is not stalled, into a registered output. Depends on tsp_pkg.
`default_nettype none
module tsp_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               head_valid,
  input  tsp_pkg::desc_t    head,
  output logic              pop,
  output logic              result_valid,
  input  wire               result_stall,
  output tsp_pkg::result_t  result
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SYNC,
    PH_PID_HI,
    PH_PID_LO,
    PH_CC,
    PH_PTR,
    PH_DATA,
    PH_PAD
  } phase_t;

  phase_t  phase;
  phase_t  ph_cur;
  phase_t  ph_next;
  result_t word;
  logic    last;
  logic    advance;

  assign advance = !result_valid || !result_stall;

  always_comb begin
    if (phase == PH_START) begin
      ph_cur = (head.hdr == HDR_NONE) ? PH_DATA : PH_SYNC;
    end else begin
      ph_cur = phase;
    end

    word.repeat_count = SINGLE_REPEAT;
    word.section_done = 1'b0;
    last              = 1'b0;
    unique case (ph_cur)
      PH_SYNC: begin
        word.out_byte = SYNC_BYTE;
        ph_next       = PH_PID_HI;
      end
      PH_PID_HI: begin
        word.out_byte = {1'b0, head.hdr == HDR_FIRST, 1'b0, head.pid[12:8]};
        ph_next       = PH_PID_LO;
      end
      PH_PID_LO: begin
        word.out_byte = head.pid[7:0];
        ph_next       = PH_CC;
      end
      PH_CC: begin
        word.out_byte = {PAYLOAD_FLAG, head.cc};
        ph_next       = (head.hdr == HDR_FIRST) ? PH_PTR : PH_DATA;
      end
      PH_PTR: begin
        word.out_byte = POINTER_BYTE;
        ph_next       = PH_DATA;
      end
      PH_DATA: begin
        word.out_byte     = head.data;
        word.section_done = head.done && (head.pad == '0);
        last              = head.pad == '0;
        ph_next           = PH_PAD;
      end
      PH_PAD: begin
        word.out_byte     = STUFF_BYTE;
        word.repeat_count = head.pad;
        word.section_done = 1'b1;
        last              = 1'b1;
        ph_next           = PH_START;
      end
      default: begin
        word.out_byte = head.data;
        ph_next       = PH_START;
      end
    endcase

    pop = advance && head_valid && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= head_valid;
      if (head_valid) begin
        result <= word;
        phase  <= last ? PH_START : ph_next;
      end
    end
  end

  a_run_is_stuff: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.repeat_count != SINGLE_REPEAT
      |-> result.out_byte == STUFF_BYTE && result.section_done)
    else $error("repeat run on a non-stuffing word");

  a_mid_needs_head: assert property (@(posedge clk) disable iff (rst)
    phase != PH_START |-> head_valid)
    else $error("descriptor left queue while being expanded");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAD |-> head.pad != '0)
    else $error("padding phase with empty run");

endmodule
`default_nettype wire

// ===== rtl/ts_section_packetizer_core.sv =====
// Top level of the transport stream section packetizer.
// Depends on tsp_pkg, tsp_front, tsp_queue and tsp_back.
//
//   channel  direction  handshake                      payload
//   item     in         item_valid / item_stall        tsp_pkg::item_t
//   result   out        result_valid / result_stall    tsp_pkg::result_t
//
// One result word leaves per cycle while a descriptor is queued and the
// output is not stalled; a byte in mid-packet yields one data word, a packet
// start adds 4 or 5 header words and a section end that needs padding adds
// one word for the stuffing run. The back end's word sequencer sets this.
// The front accepts one byte per cycle until the 4-entry descriptor queue
// fills. Reset is synchronous and clears framing, queue and output valid.
// result_stall holds the output register; item_stall follows queue full.
`default_nettype none
module ts_section_packetizer_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               item_valid,
  output logic              item_stall,
  input  tsp_pkg::item_t    item,
  output logic              result_valid,
  input  wire               result_stall,
  output tsp_pkg::result_t  result
);
  import tsp_pkg::*;

  logic  q_full;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  head_valid;
  desc_t head;

  tsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  tsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for ts_section_packetizer_core: sends PSI sections with random idling
// and stalls, and checks every result word against a packetizer model kept here.
// Depends on tsp_pkg and the packetizer RTL.
module tb_top;
  import tsp_pkg::*;

  localparam logic [7:0] START_FLAG = 8'h40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_BYTES = 40;

  class section_scoreboard;
    logic [12:0] byte_pos;
    logic [12:0] sect_len;
    logic [12:0] pid;
    logic [7:0] fill;
    logic [3:0] cc;
    bit framing;
    result_t expected_q[$];
    int errors;

    function new();
      byte_pos = '0;
      sect_len = '0;
      pid = '0;
      fill = '0;
      cc = '0;
      framing = 1'b0;
      errors = 0;
    endfunction

    function void push(logic [7:0] b, logic [7:0] rep, logic done);
      result_t r;
      r.out_byte = b;
      r.repeat_count = rep;
      r.section_done = done;
      expected_q.push_back(r);
    endfunction

    function void note_item(item_t w);
      logic [7:0] b;
      b = w.data_byte;
      if (w.first_byte) begin
        pid = w.packet_id;
        cc = w.start_count;
        byte_pos = '0;
        sect_len = '0;
        framing = 1'b1;
        push(SYNC_BYTE, SINGLE_REPEAT, 1'b0);
        push(START_FLAG | {3'b000, pid[12:8]}, SINGLE_REPEAT, 1'b0);
        push(pid[7:0], SINGLE_REPEAT, 1'b0);
        push({PAYLOAD_FLAG, cc}, SINGLE_REPEAT, 1'b0);
        push(POINTER_BYTE, SINGLE_REPEAT, 1'b0);
        fill = 8'd1;
      end else begin
        if (!framing) return;
        if (fill == 8'd0) begin
          push(SYNC_BYTE, SINGLE_REPEAT, 1'b0);
          push({3'b000, pid[12:8]}, SINGLE_REPEAT, 1'b0);
          push(pid[7:0], SINGLE_REPEAT, 1'b0);
          push({PAYLOAD_FLAG, cc}, SINGLE_REPEAT, 1'b0);
        end
      end
      if (byte_pos == 13'd1) begin
        sect_len = {1'b0, b[3:0], 8'h00};
      end else if (byte_pos == 13'd2) begin
        sect_len = (sect_len | {5'b00000, b}) + LEN_BIAS;
      end
      byte_pos = byte_pos + 13'd1;
      fill = fill + 8'd1;
      if (byte_pos >= 13'd3 && byte_pos == sect_len) begin
        framing = 1'b0;
        if (fill < PACKET_PAYLOAD) begin
          push(b, SINGLE_REPEAT, 1'b0);
          push(STUFF_BYTE, PACKET_PAYLOAD - fill, 1'b1);
        end else begin
          push(b, SINGLE_REPEAT, 1'b1);
        end
        fill = 8'd0;
        return;
      end
      push(b, SINGLE_REPEAT, 1'b0);
      if (fill >= PACKET_PAYLOAD) begin
        fill = 8'd0;
        cc = cc + 4'd1;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual byte %h repeat %0d done %0b",
                 $time, got.out_byte, got.repeat_count, got.section_done);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.repeat_count !== want.repeat_count) begin
        errors++;
        $display("%0t: repeat_count expected %0d actual %0d",
                 $time, want.repeat_count, got.repeat_count);
      end
      if (got.section_done !== want.section_done) begin
        errors++;
        $display("%0t: section_done expected %0b actual %0b",
                 $time, want.section_done, got.section_done);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;

  int src_idle_pct;
  int sink_idle_pct;
  int section_bytes;
  section_scoreboard board = new();

  ts_section_packetizer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] data, logic first, logic [12:0] id, logic [3:0] cnt);
    item_t w;
    int gap;
    w.data_byte = data;
    w.first_byte = first;
    w.packet_id = id;
    w.start_count = cnt;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 5);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(w);
    @(negedge clk);
  endtask

  // send the first `sent` bytes of a section of `total` bytes
  task automatic send_section(int total, int sent, logic [12:0] id, logic [3:0] cnt);
    logic [11:0] field;
    logic [7:0] data;
    field = 12'(total - 3);
    for (int i = 0; i < sent; i++) begin
      case (i)
        1: begin
          data = {4'($urandom_range(0, 15)), field[11:8]};
        end
        2: begin
          data = field[7:0];
        end
        default: begin
          data = 8'($urandom_range(0, 255));
        end
      endcase
      if (i == 0) begin
        send_byte(data, 1'b1, id, cnt);
      end else begin
        send_byte(data, 1'b0, 13'($urandom_range(0, 8191)), 4'($urandom_range(0, 15)));
      end
      section_bytes++;
    end
  endtask

  initial begin
    int burst;
    burst = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        if (burst == 0) result_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        burst = $urandom_range(1, 5);
        result_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_word(result);
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int kind;
    int total;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    section_bytes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 20;
    sink_idle_pct = 20;
    // drop: no section open yet
    send_byte(8'hff, 1'b0, 13'h1fff, 4'hf);
    // shortest section, then a byte past its end
    send_byte(8'h00, 1'b1, 13'h1fff, 4'hf);
    send_byte(8'hf0, 1'b0, 13'h0000, 4'h0);
    send_byte(8'h00, 1'b0, 13'h1fff, 4'hf);
    send_byte(8'h5a, 1'b0, 13'h0000, 4'h0);
    send_byte(8'hff, 1'b1, 13'h0000, 4'h0);
    send_byte(8'h00, 1'b0, 13'h1fff, 4'hf);
    send_byte(8'h03, 1'b0, 13'h0000, 4'h0);
    send_byte(8'h00, 1'b0, 13'h1fff, 4'hf);
    send_byte(8'hff, 1'b0, 13'h0000, 4'h0);
    send_byte(8'h80, 1'b0, 13'h1fff, 4'hf);
    // restart a long section after a few bytes
    send_byte(8'h42, 1'b1, 13'h0a5a, 4'h7);
    send_byte(8'h3f, 1'b0, 13'h15a5, 4'h8);
    send_byte(8'hff, 1'b0, 13'h0a5a, 4'h7);
    send_byte(8'h11, 1'b0, 13'h15a5, 4'h8);
    send_byte(8'h02, 1'b1, 13'h1555, 4'h9);
    send_byte(8'hb0, 1'b0, 13'h0aaa, 4'h6);
    send_byte(8'h01, 1'b0, 13'h1555, 4'h9);
    send_byte(8'hc3, 1'b0, 13'h0aaa, 4'h6);
    // restart right after the table id
    send_byte(8'h00, 1'b1, 13'h0100, 4'h3);
    send_byte(8'h7e, 1'b1, 13'h0080, 4'he);
    send_byte(8'h00, 1'b0, 13'h0000, 4'h0);
    send_byte(8'h00, 1'b0, 13'h0000, 4'h0);

    // exact fill of the first packet, no stuffing run
    send_section(183, 183, 13'($urandom_range(0, 8191)), 4'hf);

    section_bytes = 0;
    while (section_bytes < RANDOM_BYTES) begin
      src_idle_pct = pick_idle();
      sink_idle_pct = pick_idle();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        total = $urandom_range(3, 24);
        send_section(total, total, 13'($urandom_range(0, 8191)), 4'($urandom_range(0, 15)));
      end else if (kind < 70) begin
        total = $urandom_range(25, 60);
        send_section(total, total, 13'($urandom_range(0, 8191)), 4'($urandom_range(0, 15)));
      end else if (kind < 88) begin
        total = $urandom_range(3, 60);
        send_section(total, $urandom_range(1, total - 1), 13'($urandom_range(0, 8191)),
                     4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 13'($urandom_range(0, 8191)),
                    4'($urandom_range(0, 15)));
          section_bytes++;
        end
      end
    end

    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (3) begin
      total = $urandom_range(3, 16);
      send_section(total, total, 13'($urandom_range(0, 8191)), 4'($urandom_range(0, 15)));
    end
    item_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tsp_pkg.sv
rtl/tsp_front.sv
rtl/tsp_queue.sv
rtl/tsp_back.sv
rtl/ts_section_packetizer_core.sv
test/tb_top.sv
